>>> hdl/poc_pkg.sv
// ----------------------------------------------------------------------------
// poc_pkg
// Shared constants and elaboration-time functions for the plane orientation
// classifier: field widths, reference plane normals and derived widths.
// ----------------------------------------------------------------------------
package poc_pkg;

	localparam int FRACTION_BITS_DEF = 14;
	localparam int IN_W              = 16;
	localparam int CODE_W            = 4;
	localparam int PLANE_COUNT       = 6;
	localparam int CAND_COUNT        = 2 * PLANE_COUNT;
	localparam int PROD_IN_W         = 2 * IN_W;
	localparam int WIDE_W            = PROD_IN_W + 1;
	localparam int ROUND_W           = WIDE_W + 1;

	// Reference vectors are exact in units of 1e-4, so their cross products
	// are exact in units of 1e-8.
	localparam longint REF_UNITS_SQ = 64'd100000000;

	// Cross products of the six reference plane pairs, taken in the order
	// (first, second), in units of 1e-8.
	localparam longint PLANE_NORMAL [PLANE_COUNT][3] = '{
		'{64'sd0,         64'sd0,          64'sd100000000},
		'{64'sd0,         64'sd100000000,  64'sd0},
		'{-64'sd100000000, 64'sd0,         64'sd0},
		'{-64'sd47500000, 64'sd76000000,   64'sd13000000},
		'{64'sd8970000,   -64'sd14352000,  64'sd88330000},
		'{64'sd67059000,  64'sd65197000,   -64'sd196000}
	};

	// Signed width of one rounded image normal component.
	function automatic int img_width(input int f);
		return ROUND_W - f;
	endfunction

	// Signed width of one reference normal component (magnitude up to 2^f).
	function automatic int ref_width(input int f);
		return f + 2;
	endfunction

	// Signed width of a distance key; covers |ref|^2 and twice the dot product.
	function automatic int key_width(input int f);
		int a;
		int b;
		a = 2 * f + 3;
		b = img_width(f) + ref_width(f) + 5;
		return (a > b) ? a : b;
	endfunction

	// Reference normal component scaled to f fraction bits, rounded half away
	// from zero.
	function automatic longint ref_value(input int f, input int p, input int i);
		longint n;
		longint m;
		longint q;
		n = PLANE_NORMAL[p][i];
		m = (n < 0) ? -n : n;
		q = ((m << f) + REF_UNITS_SQ / 2) / REF_UNITS_SQ;
		return (n < 0) ? -q : q;
	endfunction

	// Squared length of a scaled reference normal.
	function automatic longint ref_norm_sq(input int f, input int p);
		longint s;
		longint v;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			v = ref_value(f, p, i);
			s = s + v * v;
		end
		return s;
	endfunction

	// Orientation code of candidate j in trial order +1, -1, +2, -2, ...
	function automatic logic signed [CODE_W-1:0] cand_code(input int j);
		int k;
		k = j / 2 + 1;
		return (j % 2 == 0) ? CODE_W'(k) : CODE_W'(-k);
	endfunction

endpackage

>>> hdl/poc_normal.sv
// ----------------------------------------------------------------------------
// poc_normal
// Image plane normal: the six partial products of the cross product are
// registered, then each component is formed and rounded to the input format.
// ----------------------------------------------------------------------------
module poc_normal #(
	parameter int FRACTION_BITS = poc_pkg::FRACTION_BITS_DEF,
	parameter int IMG_W         = poc_pkg::img_width(poc_pkg::FRACTION_BITS_DEF)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [poc_pkg::IN_W-1:0]    row_x,
	input  logic signed [poc_pkg::IN_W-1:0]    row_y,
	input  logic signed [poc_pkg::IN_W-1:0]    row_z,
	input  logic signed [poc_pkg::IN_W-1:0]    col_x,
	input  logic signed [poc_pkg::IN_W-1:0]    col_y,
	input  logic signed [poc_pkg::IN_W-1:0]    col_z,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [IMG_W-1:0]            img [3]
);
	import poc_pkg::*;

	localparam logic signed [ROUND_W-1:0] HALF =
		ROUND_W'(longint'(1) << (FRACTION_BITS - 1));

	logic                          v_s1;
	logic                          v_s2;
	logic                          en_s1;
	logic                          en_s2;
	logic signed [PROD_IN_W-1:0]   prod_s1 [6];
	logic signed [PROD_IN_W-1:0]   prod_d  [6];
	logic signed [IMG_W-1:0]       img_s2  [3];
	logic signed [IMG_W-1:0]       img_d   [3];

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// Pairs ordered so that component i is prod[2i] - prod[2i+1].
	always_comb begin
		prod_d[0] = PROD_IN_W'(row_y) * PROD_IN_W'(col_z);
		prod_d[1] = PROD_IN_W'(row_z) * PROD_IN_W'(col_y);
		prod_d[2] = PROD_IN_W'(row_z) * PROD_IN_W'(col_x);
		prod_d[3] = PROD_IN_W'(row_x) * PROD_IN_W'(col_z);
		prod_d[4] = PROD_IN_W'(row_x) * PROD_IN_W'(col_y);
		prod_d[5] = PROD_IN_W'(row_y) * PROD_IN_W'(col_x);
	end

	// Floor of (w + half - [w < 0]) / 2^F rounds half away from zero.
	always_comb begin
		logic signed [WIDE_W-1:0]  wide;
		logic signed [ROUND_W-1:0] sum;
		for (int i = 0; i < 3; i++) begin
			wide     = WIDE_W'(prod_s1[2*i]) - WIDE_W'(prod_s1[2*i+1]);
			sum      = ROUND_W'(wide) + HALF - (wide[WIDE_W-1] ? ROUND_W'(1) : ROUND_W'(0));
			img_d[i] = IMG_W'(sum >>> FRACTION_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) prod_s1 <= prod_d;
		if (en_s2) img_s2  <= img_d;
	end

	assign out_valid = v_s2;
	assign img       = img_s2;

endmodule

>>> hdl/poc_score.sv
// ----------------------------------------------------------------------------
// poc_score
// Distance keys: the squared distance to each reference normal, less the
// common |img|^2 term, is |ref|^2 - 2 img.ref; the reversed order flips the
// sign of the dot product. Products and keys each get a register stage.
// ----------------------------------------------------------------------------
module poc_score #(
	parameter int FRACTION_BITS = poc_pkg::FRACTION_BITS_DEF,
	parameter int IMG_W         = poc_pkg::img_width(poc_pkg::FRACTION_BITS_DEF),
	parameter int KEY_W         = poc_pkg::key_width(poc_pkg::FRACTION_BITS_DEF)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [IMG_W-1:0] img [3],
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [KEY_W-1:0] keys [poc_pkg::CAND_COUNT]
);
	import poc_pkg::*;

	localparam int REF_W  = ref_width(FRACTION_BITS);
	localparam int PROD_W = IMG_W + REF_W;

	logic                    v_s3;
	logic                    v_s4;
	logic                    en_s3;
	logic                    en_s4;
	logic signed [PROD_W-1:0] prod_d  [PLANE_COUNT][3];
	logic signed [PROD_W-1:0] prod_s3 [PLANE_COUNT][3];
	logic signed [KEY_W-1:0]  key_d   [CAND_COUNT];
	logic signed [KEY_W-1:0]  key_s4  [CAND_COUNT];

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
		localparam logic signed [KEY_W-1:0] NSQ = KEY_W'(ref_norm_sq(FRACTION_BITS, p));
		logic signed [KEY_W-1:0] dot2;

		for (genvar i = 0; i < 3; i++) begin : g_comp
			localparam logic signed [PROD_W-1:0] RC =
				PROD_W'(ref_value(FRACTION_BITS, p, i));
			assign prod_d[p][i] = PROD_W'(img[i]) * RC;
		end

		assign dot2 = (KEY_W'(prod_s3[p][0]) + KEY_W'(prod_s3[p][1])
			+ KEY_W'(prod_s3[p][2])) <<< 1;
		assign key_d[2*p]   = NSQ - dot2;
		assign key_d[2*p+1] = NSQ + dot2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) prod_s3 <= prod_d;
		if (en_s4) key_s4  <= key_d;
	end

	assign out_valid = v_s4;
	assign keys      = key_s4;

endmodule

>>> hdl/poc_select.sv
// ----------------------------------------------------------------------------
// poc_select
// Registered minimum tree over the twelve candidate keys (12 to 6 to 3 to 1).
// The right side wins only when strictly smaller, so the earliest minimum in
// trial order is kept.
// ----------------------------------------------------------------------------
module poc_select #(
	parameter int KEY_W = poc_pkg::key_width(poc_pkg::FRACTION_BITS_DEF)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [KEY_W-1:0]            keys [poc_pkg::CAND_COUNT],
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [poc_pkg::CODE_W-1:0]  code
);
	import poc_pkg::*;

	logic                     v_s5;
	logic                     v_s6;
	logic                     v_s7;
	logic                     en_s5;
	logic                     en_s6;
	logic                     en_s7;
	logic signed [CODE_W-1:0] cand    [CAND_COUNT];
	logic signed [KEY_W-1:0]  key5_d  [6];
	logic signed [CODE_W-1:0] code5_d [6];
	logic signed [KEY_W-1:0]  key_s5  [6];
	logic signed [CODE_W-1:0] code_s5 [6];
	logic signed [KEY_W-1:0]  key6_d  [3];
	logic signed [CODE_W-1:0] code6_d [3];
	logic signed [KEY_W-1:0]  key_s6  [3];
	logic signed [CODE_W-1:0] code_s6 [3];
	logic signed [CODE_W-1:0] code7_d;
	logic signed [CODE_W-1:0] code_s7;

	assign en_s7    = !v_s7 || out_ready;
	assign en_s6    = !v_s6 || en_s7;
	assign en_s5    = !v_s5 || en_s6;
	assign in_ready = en_s5;

	for (genvar j = 0; j < CAND_COUNT; j++) begin : g_code
		assign cand[j] = cand_code(j);
	end

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			if (keys[2*j+1] < keys[2*j]) begin
				key5_d[j]  = keys[2*j+1];
				code5_d[j] = cand[2*j+1];
			end else begin
				key5_d[j]  = keys[2*j];
				code5_d[j] = cand[2*j];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (key_s5[2*j+1] < key_s5[2*j]) begin
				key6_d[j]  = key_s5[2*j+1];
				code6_d[j] = code_s5[2*j+1];
			end else begin
				key6_d[j]  = key_s5[2*j];
				code6_d[j] = code_s5[2*j];
			end
		end
	end

	always_comb begin
		logic signed [KEY_W-1:0]  k01;
		logic signed [CODE_W-1:0] c01;
		if (key_s6[1] < key_s6[0]) begin
			k01 = key_s6[1];
			c01 = code_s6[1];
		end else begin
			k01 = key_s6[0];
			c01 = code_s6[0];
		end
		code7_d = (key_s6[2] < k01) ? code_s6[2] : c01;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s5) v_s5 <= in_valid;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			key_s5  <= key5_d;
			code_s5 <= code5_d;
		end
		if (en_s6) begin
			key_s6  <= key6_d;
			code_s6 <= code6_d;
		end
		if (en_s7) code_s7 <= code7_d;
	end

	assign out_valid = v_s7;
	assign code      = code_s7;

endmodule

>>> hdl/plane_orientation_classifier.sv
// Throughput: one item per cycle while the output is not stalled; seven pipeline stages, each with a valid bit.
// A stall at the output holds the pipeline and fills its empty stages.
// Reset (arst_n low) clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// plane_orientation_classifier
// Classifies an image plane by the reference normal closest to the cross
// product of its row and column direction cosines.
// ----------------------------------------------------------------------------
module plane_orientation_classifier #(
	parameter int FRACTION_BITS = poc_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic signed [poc_pkg::IN_W-1:0]   row_x,
	input  logic signed [poc_pkg::IN_W-1:0]   row_y,
	input  logic signed [poc_pkg::IN_W-1:0]   row_z,
	input  logic signed [poc_pkg::IN_W-1:0]   col_x,
	input  logic signed [poc_pkg::IN_W-1:0]   col_y,
	input  logic signed [poc_pkg::IN_W-1:0]   col_z,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic signed [poc_pkg::CODE_W-1:0] orientation_code
);
	import poc_pkg::*;

	localparam int IMG_W = img_width(FRACTION_BITS);
	localparam int KEY_W = key_width(FRACTION_BITS);

	logic                    img_valid;
	logic                    img_ready;
	logic signed [IMG_W-1:0] img [3];
	logic                    key_valid;
	logic                    key_ready;
	logic signed [KEY_W-1:0] keys [CAND_COUNT];

	poc_normal #(
		.FRACTION_BITS (FRACTION_BITS),
		.IMG_W         (IMG_W)
	) u_normal (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_valid),
		.in_ready  (item_ready),
		.row_x     (row_x),
		.row_y     (row_y),
		.row_z     (row_z),
		.col_x     (col_x),
		.col_y     (col_y),
		.col_z     (col_z),
		.out_valid (img_valid),
		.out_ready (img_ready),
		.img       (img)
	);

	poc_score #(
		.FRACTION_BITS (FRACTION_BITS),
		.IMG_W         (IMG_W),
		.KEY_W         (KEY_W)
	) u_score (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (img_valid),
		.in_ready  (img_ready),
		.img       (img),
		.out_valid (key_valid),
		.out_ready (key_ready),
		.keys      (keys)
	);

	poc_select #(
		.KEY_W (KEY_W)
	) u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (key_valid),
		.in_ready  (key_ready),
		.keys      (keys),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.code      (orientation_code)
	);

endmodule
